FILE: rtl/binary_gps_frame_deframer_assert.svh
// Assertion macros for the binary frame deframer.
// Used by the top level only; no other dependencies.
`ifndef BINARY_GPS_FRAME_DEFRAMER_ASSERT_SVH
`define BINARY_GPS_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define BGD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define BGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BGD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define BGD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/bgd_pkg.sv
// Shared types and constants for the binary frame deframer.
// No dependencies.
`default_nettype none

package bgd_pkg;

  localparam int LEN_W = 15;

  // Frame marker bytes
  localparam logic [7:0] START1_BYTE = 8'hA0;
  localparam logic [7:0] START2_BYTE = 8'hA2;
  localparam logic [7:0] END1_BYTE   = 8'hB0;
  localparam logic [7:0] END2_BYTE   = 8'hB3;
  localparam logic [7:0] HIGH_MAX    = 8'h7F;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 15'd1023;

  typedef enum logic [8:0] {
    PH_START1 = 9'b000000001,
    PH_START2 = 9'b000000010,
    PH_LEN_HI = 9'b000000100,
    PH_LEN_LO = 9'b000001000,
    PH_DATA   = 9'b000010000,
    PH_SUM_HI = 9'b000100000,
    PH_SUM_LO = 9'b001000000,
    PH_END1   = 9'b010000000,
    PH_END2   = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_BYTE   = 3'd1,
    EV_GOOD   = 3'd2,
    EV_BADSUM = 3'd3,
    EV_DROP   = 3'd4
  } event_t;

  typedef struct packed {
    event_t           ev;
    logic [7:0]       pbyte;
    logic [LEN_W-1:0] pidx;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/bgd_core.sv
// Frame state machine: phase, length, count and checksum registers.
// Depends on bgd_pkg.
`default_nettype none

module bgd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [7:0]                  data_byte,
  input  logic [bgd_pkg::LEN_W-1:0]   max_payload,
  output bgd_pkg::result_t            result
);

  bgd_pkg::phase_t             phase, phase_next;
  logic [bgd_pkg::LEN_W-1:0]   frame_length, frame_length_next;
  logic [bgd_pkg::LEN_W-1:0]   bytes_received, bytes_received_next;
  logic [6:0]                  high_byte_hold, high_byte_hold_next;
  logic [bgd_pkg::LEN_W-1:0]   received_sum, received_sum_next;
  logic [bgd_pkg::LEN_W-1:0]   running_sum, running_sum_next;

  logic [bgd_pkg::LEN_W-1:0]   len_word;
  logic [bgd_pkg::LEN_W-1:0]   count_inc;
  logic [bgd_pkg::LEN_W-1:0]   sum_add;

  assign len_word  = {high_byte_hold, data_byte};
  assign count_inc = bytes_received + 15'd1;
  assign sum_add   = running_sum + {7'd0, data_byte};

  always_comb begin
    phase_next          = phase;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    high_byte_hold_next = high_byte_hold;
    received_sum_next   = received_sum;
    running_sum_next    = running_sum;
    result.ev           = bgd_pkg::EV_NONE;
    result.pbyte        = 8'd0;
    result.pidx         = '0;

    case (phase)
      bgd_pkg::PH_START2: begin
        phase_next = (data_byte == bgd_pkg::START2_BYTE) ? bgd_pkg::PH_LEN_HI
                                                         : bgd_pkg::PH_START1;
      end
      bgd_pkg::PH_LEN_HI: begin
        if (data_byte <= bgd_pkg::HIGH_MAX) begin
          high_byte_hold_next = data_byte[6:0];
          phase_next          = bgd_pkg::PH_LEN_LO;
        end else begin
          phase_next = bgd_pkg::PH_START1;
        end
      end
      bgd_pkg::PH_LEN_LO: begin
        frame_length_next   = len_word;
        bytes_received_next = '0;
        running_sum_next    = '0;
        if (len_word > max_payload) begin
          phase_next = bgd_pkg::PH_START1;
        end else if (len_word == '0) begin
          phase_next = bgd_pkg::PH_SUM_HI;
        end else begin
          phase_next = bgd_pkg::PH_DATA;
        end
      end
      bgd_pkg::PH_DATA: begin
        result.ev           = bgd_pkg::EV_BYTE;
        result.pbyte        = data_byte;
        result.pidx         = bytes_received;
        running_sum_next    = sum_add;
        bytes_received_next = count_inc;
        if (count_inc == frame_length) begin
          phase_next = bgd_pkg::PH_SUM_HI;
        end
      end
      bgd_pkg::PH_SUM_HI: begin
        if (data_byte <= bgd_pkg::HIGH_MAX) begin
          high_byte_hold_next = data_byte[6:0];
          phase_next          = bgd_pkg::PH_SUM_LO;
        end else begin
          result.ev  = bgd_pkg::EV_DROP;
          phase_next = bgd_pkg::PH_START1;
        end
      end
      bgd_pkg::PH_SUM_LO: begin
        received_sum_next = len_word;
        phase_next        = bgd_pkg::PH_END1;
      end
      bgd_pkg::PH_END1: begin
        if (data_byte == bgd_pkg::END1_BYTE) begin
          phase_next = bgd_pkg::PH_END2;
        end else begin
          result.ev  = bgd_pkg::EV_DROP;
          phase_next = bgd_pkg::PH_START1;
        end
      end
      bgd_pkg::PH_END2: begin
        if (data_byte == bgd_pkg::END2_BYTE) begin
          result.ev = (running_sum == received_sum) ? bgd_pkg::EV_GOOD
                                                    : bgd_pkg::EV_BADSUM;
        end else begin
          result.ev = bgd_pkg::EV_DROP;
        end
        bytes_received_next = '0;
        phase_next          = bgd_pkg::PH_START1;
      end
      default: begin
        phase_next = (data_byte == bgd_pkg::START1_BYTE) ? bgd_pkg::PH_START2
                                                         : bgd_pkg::PH_START1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= bgd_pkg::PH_START1;
      frame_length   <= '0;
      bytes_received <= '0;
      high_byte_hold <= '0;
      received_sum   <= '0;
      running_sum    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      high_byte_hold <= high_byte_hold_next;
      received_sum   <= received_sum_next;
      running_sum    <= running_sum_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bgd_outbuf.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on bgd_pkg.
`default_nettype none

module bgd_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bgd_pkg::result_t result,
  output logic             out_valid,
  input  logic             out_ready,
  output bgd_pkg::result_t held
);

  // Takes a new result when empty or when the held one leaves this cycle
  assign in_ready = !rst && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/binary_gps_frame_deframer.sv
// Top level of the binary frame deframer: config register, frame FSM, result register.
// Depends on bgd_pkg, bgd_core, bgd_outbuf and binary_gps_frame_deframer_assert.svh.
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   input    | in_valid/in_ready, data_byte          | in
//   output   | out_valid/out_ready, event_res,       | out
//            | payload_byte, payload_index           |
//   config   | cfg_wr_en, cfg_wr_data (max_payload)  | in
//
// One byte per cycle: each transfer goes through the frame FSM's next-state
// logic (15-bit adds and compares) straight into the result register.
// out_valid rises in the cycle after the input transfer.
// A stalled output holds in_ready low until the held result is taken;
// a result leaving in the same cycle frees the slot for the next byte.
// Synchronous reset clears the FSM, the result valid flag and sets
// max_payload to 1023; in_ready is low while rst is high.
`default_nettype none

`include "binary_gps_frame_deframer_assert.svh"

module binary_gps_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [14:0] payload_index,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
);

  logic [bgd_pkg::LEN_W-1:0] max_payload;
  logic                      in_xfer;
  bgd_pkg::result_t          core_result;
  bgd_pkg::result_t          held;

  // Single configuration register, write-only
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= bgd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  assign in_xfer = in_valid && in_ready;

  // Frame FSM advances only on an input transfer
  bgd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_xfer),
    .data_byte   (data_byte),
    .max_payload (max_payload),
    .result      (core_result)
  );

  bgd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .result    (core_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign event_res     = held.ev;
  assign payload_byte  = held.pbyte;
  assign payload_index = held.pidx;

  // Every input transfer produces a result in the next cycle
  `BGD_ASSERT_NEXT(a_xfer_gives_result, clk, rst, in_xfer, out_valid)
  // Payload fields are zero unless the result is a payload byte
  `BGD_ASSERT_IMPLY(a_payload_zero, clk, rst,
    out_valid && (event_res != bgd_pkg::EV_BYTE),
    (payload_byte == 8'd0) && (payload_index == 15'd0))
  // A consecutive payload byte carries the next index
  `BGD_ASSERT_NEXT(a_index_steps, clk, rst,
    in_xfer && out_valid && out_ready && (event_res == bgd_pkg::EV_BYTE)
      && (core_result.ev == bgd_pkg::EV_BYTE),
    payload_index == $past(payload_index) + 15'd1)

endmodule

`default_nettype wire
